// File: sv/acbe_pkg.sv
package acbe_pkg;

   localparam int MAX_ROUNDS = 14;
   localparam int RK_DEPTH = MAX_ROUNDS + 1;
   localparam int RK_AW = $clog2(RK_DEPTH);
   localparam int KX_CNT_W = $clog2(4 * RK_DEPTH);

   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [2:0] CSR_KEY_SIZE   = 3'd4;
   localparam logic [2:0] CSR_IV_UPPER   = 3'd5;
   localparam logic [2:0] CSR_IV_LOWER   = 3'd6;

   localparam logic [1:0] KEY_SIZE_128 = 2'd0;
   localparam logic [1:0] KEY_SIZE_192 = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEXP,
      ST_ISSUE,
      ST_ARK,
      ST_ROUND
   } acbe_state_type;

   typedef struct packed {
      logic capture;
      logic kexp_start;
      logic kexp_run;
      logic step_run;
      logic ark;
      logic round_run;
      logic finish;
   } acbe_cmd_type;

   typedef struct packed {
      logic key_dirty;
      logic kexp_last;
      logic last_round;
      logic out_free;
   } acbe_status_type;

   localparam logic [2047:0] SBOX_FWD = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   localparam logic [2047:0] SBOX_INV = {
      128'h52096ad53036a538bf40a39e81f3d7fb,
      128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e,
      128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692,
      128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506,
      128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673,
      128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b,
      128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f,
      128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961,
      128'h172b047eba77d626e169146355210c7d
   };

   function automatic logic [7:0] sbox(input logic [7:0] x);
      int idx;
      idx = 255 - int'(x);
      return SBOX_FWD[idx * 8 +: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      int idx;
      idx = 255 - int'(x);
      return SBOX_INV[idx * 8 +: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] w);
      logic [7:0] a0, a1, a2, a3;
      logic [7:0] d0, d1, d2, d3;
      a0 = w[31:24];
      a1 = w[23:16];
      a2 = w[15:8];
      a3 = w[7:0];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
              a0 ^ d1 ^ d2 ^ a2 ^ a3,
              a0 ^ a1 ^ d2 ^ d3 ^ a3,
              d0 ^ a0 ^ a1 ^ a2 ^ d3};
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
      logic [7:0] a[4];
      logic [7:0] m9[4], m11[4], m13[4], m14[4];
      logic [7:0] x2, x4, x8;
      for (int k = 0; k < 4; k++) begin
         a[k] = w[31 - 8 * k -: 8];
         x2 = xtime(a[k]);
         x4 = xtime(x2);
         x8 = xtime(x4);
         m9[k] = x8 ^ a[k];
         m11[k] = x8 ^ x2 ^ a[k];
         m13[k] = x8 ^ x4 ^ a[k];
         m14[k] = x8 ^ x4 ^ x2;
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0] b[16];
      logic [7:0] t[16];
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
         b[i] = sbox(s[127 - 8 * i -: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4 * c] = b[r + 4 * ((c + r) % 4)];
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[127 - 8 * i -: 8] = t[i];
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            o[127 - 32 * c -: 32] = mix_col(o[127 - 32 * c -: 32]);
         end
      end
      return o ^ rk;
   endfunction

   function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0] t[16];
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4 * ((c + r) % 4)] = s[127 - 8 * (r + 4 * c) -: 8];
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[127 - 8 * i -: 8] = inv_sbox(t[i]);
      end
      o = o ^ rk;
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            o[127 - 32 * c -: 32] = inv_mix_col(o[127 - 32 * c -: 32]);
         end
      end
      return o;
   endfunction

endpackage

// File: sv/acbe_ram.sv
module acbe_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/acbe_ctrl.sv
module acbe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  acbe_pkg::acbe_status_type status,
   output acbe_pkg::acbe_cmd_type    cmd
);

   acbe_pkg::acbe_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acbe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         acbe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.key_dirty) begin
                  cmd.kexp_start = 1'b1;
                  state_in = acbe_pkg::ST_KEXP;
               end else begin
                  state_in = acbe_pkg::ST_ISSUE;
               end
            end
         end
         acbe_pkg::ST_KEXP: begin
            cmd.kexp_run = 1'b1;
            if (status.kexp_last) begin
               state_in = acbe_pkg::ST_ISSUE;
            end
         end
         acbe_pkg::ST_ISSUE: begin
            cmd.step_run = 1'b1;
            state_in = acbe_pkg::ST_ARK;
         end
         acbe_pkg::ST_ARK: begin
            cmd.step_run = 1'b1;
            cmd.ark = 1'b1;
            state_in = acbe_pkg::ST_ROUND;
         end
         acbe_pkg::ST_ROUND: begin
            if (status.last_round) begin
               if (status.out_free) begin
                  cmd.finish = 1'b1;
                  state_in = acbe_pkg::ST_IDLE;
               end
            end else begin
               cmd.round_run = 1'b1;
               cmd.step_run = 1'b1;
            end
         end
         default: begin
            state_in = acbe_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/acbe_dp.sv
module acbe_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  acbe_pkg::acbe_cmd_type    cmd,
   output acbe_pkg::acbe_status_type status,
   input  logic                      req_action,
   input  logic [63:0]               req_data_upper,
   input  logic [63:0]               req_data_lower,
   input  logic                      req_final_block,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [63:0]               rsp_result_upper,
   output logic [63:0]               rsp_result_lower,
   output logic                      rsp_result_final,
   input  logic                      csr_write_enable,
   input  logic [2:0]                csr_index,
   input  logic [63:0]               csr_write_data
);

   logic [63:0] key_ff [4];
   logic [1:0]  key_size_ff;
   logic [63:0] iv_upper_ff, iv_lower_ff;
   logic        key_dirty_ff;

   logic [127:0] chain_ff;
   logic [127:0] data_ff;
   logic [127:0] state_ff;
   logic         fresh_ff;
   logic         dec_ff;
   logic         final_ff;

   logic [acbe_pkg::RK_AW-1:0] step_ff;

   logic [acbe_pkg::KX_CNT_W-1:0] kx_i_ff;
   logic [2:0]                    kx_mod_ff;
   logic [7:0]                    rcon_ff;
   logic [31:0]                   hist_ff [8];
   logic [95:0]                   row_ff;

   logic [127:0] rsp_data_ff;
   logic         rsp_final_ff;
   logic         rsp_valid_ff;

   logic [3:0]  nk;
   logic [acbe_pkg::RK_AW-1:0] nr;
   logic [acbe_pkg::KX_CNT_W-1:0] kx_total;
   logic [31:0] key_words [8];
   logic [31:0] kx_t;
   logic [31:0] kx_new;
   logic [31:0] kx_word;
   logic        kx_past_key;
   logic        ram_wr_en;
   logic [acbe_pkg::RK_AW-1:0] ram_rd_addr;
   logic [127:0] rk;
   logic [127:0] chain_sel;
   logic [127:0] req_block;
   logic [127:0] round_out;
   logic [127:0] result;
   logic         out_free;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         key_words[2 * k] = key_ff[k][63:32];
         key_words[2 * k + 1] = key_ff[k][31:0];
      end
      case (key_size_ff)
         acbe_pkg::KEY_SIZE_128: nk = 4'd4;
         acbe_pkg::KEY_SIZE_192: nk = 4'd6;
         default: nk = 4'd8;
      endcase
      if (nk + 4'd6 > 4'(acbe_pkg::MAX_ROUNDS)) begin
         nr = acbe_pkg::RK_AW'(acbe_pkg::MAX_ROUNDS);
      end else begin
         nr = acbe_pkg::RK_AW'(nk + 4'd6);
      end
      kx_total = acbe_pkg::KX_CNT_W'({nr + 1'b1, 2'b00});
   end

   always_comb begin
      kx_past_key = {1'b0, kx_i_ff} >= (acbe_pkg::KX_CNT_W + 1)'(nk);
      if (kx_mod_ff == 3'd0) begin
         kx_t = acbe_pkg::sub_word({hist_ff[0][23:0], hist_ff[0][31:24]}) ^ {rcon_ff, 24'd0};
      end else if (nk == 4'd8 && kx_mod_ff == 3'd4) begin
         kx_t = acbe_pkg::sub_word(hist_ff[0]);
      end else begin
         kx_t = hist_ff[0];
      end
      kx_new = hist_ff[nk[2:0] - 3'd1] ^ kx_t;
      kx_word = kx_past_key ? kx_new : key_words[kx_i_ff[2:0]];
      ram_wr_en = cmd.kexp_run && kx_i_ff[1:0] == 2'b11;
   end

   always_comb begin
      if (step_ff > nr) begin
         ram_rd_addr = dec_ff ? '0 : nr;
      end else if (dec_ff) begin
         ram_rd_addr = nr - step_ff;
      end else begin
         ram_rd_addr = step_ff;
      end
   end

   acbe_ram #(
      .WIDTH(128),
      .DEPTH(acbe_pkg::RK_DEPTH)
   ) u_rk_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(kx_i_ff[acbe_pkg::KX_CNT_W-1:2]),
      .wr_data({row_ff, kx_word}),
      .rd_addr(ram_rd_addr),
      .rd_data(rk)
   );

   always_comb begin
      chain_sel = fresh_ff ? {iv_upper_ff, iv_lower_ff} : chain_ff;
      req_block = {req_data_upper, req_data_lower};
      if (dec_ff) begin
         round_out = acbe_pkg::dec_round(state_ff, rk, status.last_round);
      end else begin
         round_out = acbe_pkg::enc_round(state_ff, rk, status.last_round);
      end
      result = dec_ff ? (round_out ^ chain_ff) : round_out;
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            key_ff[k] <= '0;
         end
         key_size_ff <= '0;
         iv_upper_ff <= '0;
         iv_lower_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            acbe_pkg::CSR_KEY_WORD_0: key_ff[0] <= csr_write_data;
            acbe_pkg::CSR_KEY_WORD_1: key_ff[1] <= csr_write_data;
            acbe_pkg::CSR_KEY_WORD_2: key_ff[2] <= csr_write_data;
            acbe_pkg::CSR_KEY_WORD_3: key_ff[3] <= csr_write_data;
            acbe_pkg::CSR_KEY_SIZE:   key_size_ff <= csr_write_data[1:0];
            acbe_pkg::CSR_IV_UPPER:   iv_upper_ff <= csr_write_data;
            acbe_pkg::CSR_IV_LOWER:   iv_lower_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_dirty_ff <= 1'b1;
      end else if (csr_write_enable && csr_index <= acbe_pkg::CSR_KEY_SIZE) begin
         key_dirty_ff <= 1'b1;
      end else if (cmd.kexp_start) begin
         key_dirty_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kexp_start) begin
         kx_i_ff <= '0;
         kx_mod_ff <= '0;
         rcon_ff <= 8'h01;
         for (int k = 0; k < 8; k++) begin
            if (k < int'(nk)) begin
               hist_ff[k] <= key_words[int'(nk) - 1 - k];
            end else begin
               hist_ff[k] <= '0;
            end
         end
      end else if (cmd.kexp_run) begin
         kx_i_ff <= kx_i_ff + 1'b1;
         kx_mod_ff <= ({1'b0, kx_mod_ff} == nk - 4'd1) ? 3'd0 : kx_mod_ff + 3'd1;
         row_ff <= {row_ff[63:0], kx_word};
         if (kx_past_key) begin
            hist_ff[0] <= kx_new;
            for (int k = 1; k < 8; k++) begin
               hist_ff[k] <= hist_ff[k - 1];
            end
            if (kx_mod_ff == 3'd0) begin
               rcon_ff <= acbe_pkg::xtime(rcon_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         chain_ff <= chain_sel;
         data_ff <= req_block;
         dec_ff <= req_action;
         final_ff <= req_final_block;
         state_ff <= req_action ? req_block : (req_block ^ chain_sel);
         step_ff <= '0;
      end else begin
         if (cmd.step_run) begin
            step_ff <= step_ff + 1'b1;
         end
         if (cmd.ark) begin
            state_ff <= state_ff ^ rk;
         end else if (cmd.round_run) begin
            state_ff <= round_out;
         end
         if (cmd.finish) begin
            chain_ff <= dec_ff ? data_ff : round_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
      end else if (cmd.finish) begin
         fresh_ff <= final_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= result;
         rsp_final_ff <= final_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.key_dirty = key_dirty_ff;
   assign status.kexp_last = kx_i_ff == kx_total - 1'b1;
   assign status.last_round = {1'b0, step_ff} == nr + 1'b1;
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_upper = rsp_data_ff[127:64];
   assign rsp_result_lower = rsp_data_ff[63:0];
   assign rsp_result_final = rsp_final_ff;

endmodule

// File: sv/aes_cbc_block_engine_top.sv
// A beat is loaded, its first round key is fetched and added, and then one cipher round per
// cycle runs for AES-128, AES-192 or AES-256; the last round waits until the response register is free.
// A new beat is accepted only once the previous result is registered and the engine is back in idle.
// After reset or any key word or key size write, the first beat adds key expansion of
// 4 * (Nr + 1) words (44, 52 or 60), one key word per cycle, stored into the round key RAM by rows of four.
// Reset is synchronous and active high; it clears the CSRs and the response valid flag and restarts the chain.
module aes_cbc_block_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [63:0] req_data_upper,
   input  logic [63:0] req_data_lower,
   input  logic        req_final_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_upper,
   output logic [63:0] rsp_result_lower,
   output logic        rsp_result_final,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   acbe_pkg::acbe_cmd_type    cmd;
   acbe_pkg::acbe_status_type status;

   acbe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   acbe_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_data_upper  (req_data_upper),
      .req_data_lower  (req_data_lower),
      .req_final_block (req_final_block),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_upper(rsp_result_upper),
      .rsp_result_lower(rsp_result_lower),
      .rsp_result_final(rsp_result_final),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

endmodule

// File: test/acbe_checker.sv
module acbe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [63:0] req_data_upper,
   input  logic [63:0] req_data_lower,
   input  logic        req_final_block,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_result_upper,
   input  logic [63:0] rsp_result_lower,
   input  logic        rsp_result_final,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] upper;
      logic [63:0] lower;
      logic        last;
   } block_result_type;

   logic [63:0]      key_words[4];
   logic [1:0]       key_code;
   logic [63:0]      iv_hi, iv_lo;
   logic [127:0]     chain_value;
   logic             new_message;
   logic [7:0]       sub_tab[256];
   logic [7:0]       unsub_tab[256];
   logic [127:0]     round_keys[15];
   int               round_count;
   block_result_type cipher_results[$];
   int               error_count;

   assign failures = error_count;
   assign pending = cipher_results.size();

   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic logic [7:0] rotate_byte(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   initial begin
      logic [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         if (x != 0) begin
            inv = 8'h01;
            repeat (254) inv = gf_product(inv, 8'(x));
         end
         b = inv ^ rotate_byte(inv, 1) ^ rotate_byte(inv, 2) ^ rotate_byte(inv, 3)
             ^ rotate_byte(inv, 4) ^ 8'h63;
         sub_tab[x] = b;
         unsub_tab[b] = 8'(x);
      end
   end

   function automatic logic [31:0] sub_all(input logic [31:0] v);
      return {sub_tab[v[31:24]], sub_tab[v[23:16]], sub_tab[v[15:8]], sub_tab[v[7:0]]};
   endfunction

   function automatic void build_round_keys();
      logic [31:0] w[60];
      logic [31:0] t;
      logic [7:0]  rc;
      int nk, total;
      nk = (key_code == acbe_pkg::KEY_SIZE_128) ? 4 :
           (key_code == acbe_pkg::KEY_SIZE_192) ? 6 : 8;
      round_count = nk + 6;
      if (round_count > acbe_pkg::MAX_ROUNDS) round_count = acbe_pkg::MAX_ROUNDS;
      total = 4 * (round_count + 1);
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         w[i] = i[0] ? key_words[i / 2][31:0] : key_words[i / 2][63:32];
      for (int i = nk; i < total; i++) begin
         t = w[i - 1];
         if (i % nk == 0) begin
            t = sub_all({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_all(t);
         end
         w[i] = w[i - nk] ^ t;
      end
      for (int j = 0; j <= round_count; j++)
         round_keys[j] = {w[4 * j], w[4 * j + 1], w[4 * j + 2], w[4 * j + 3]};
   endfunction

   function automatic logic [31:0] mix_word(input logic [31:0] col, input logic [31:0] coef);
      logic [31:0] o;
      logic [7:0]  acc;
      for (int j = 0; j < 4; j++) begin
         acc = '0;
         for (int k = 0; k < 4; k++)
            acc ^= gf_product(col[31 - 8 * k -: 8], coef[31 - 8 * ((k - j + 4) % 4) -: 8]);
         o[31 - 8 * j -: 8] = acc;
      end
      return o;
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
      logic [127:0] s, t;
      s = blk ^ round_keys[0];
      for (int r = 1; r <= round_count; r++) begin
         for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = sub_tab[s[127 - 8 * i -: 8]];
         for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++)
               t[127 - 8 * (row + 4 * c) -: 8] = s[127 - 8 * (row + 4 * ((c + row) % 4)) -: 8];
         s = t;
         if (r != round_count)
            for (int c = 0; c < 4; c++)
               s[127 - 32 * c -: 32] = mix_word(s[127 - 32 * c -: 32], 32'h02030101);
         s ^= round_keys[r];
      end
      return s;
   endfunction

   function automatic logic [127:0] decrypt_block(input logic [127:0] blk);
      logic [127:0] s, t;
      s = blk ^ round_keys[round_count];
      for (int r = round_count; r >= 1; r--) begin
         for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++)
               t[127 - 8 * (row + 4 * ((c + row) % 4)) -: 8] = s[127 - 8 * (row + 4 * c) -: 8];
         for (int i = 0; i < 16; i++) s[127 - 8 * i -: 8] = unsub_tab[t[127 - 8 * i -: 8]];
         s ^= round_keys[r - 1];
         if (r != 1)
            for (int c = 0; c < 4; c++)
               s[127 - 32 * c -: 32] = mix_word(s[127 - 32 * c -: 32], 32'h0e0b0d09);
      end
      return s;
   endfunction

   function automatic block_result_type chain_step(input logic dec, input logic [127:0] blk,
                                                   input logic last);
      block_result_type res;
      logic [127:0] o;
      build_round_keys();
      if (new_message) chain_value = {iv_hi, iv_lo};
      if (dec) begin
         o = decrypt_block(blk) ^ chain_value;
         chain_value = blk;
      end else begin
         o = encrypt_block(blk ^ chain_value);
         chain_value = o;
      end
      new_message = last;
      res.upper = o[127:64];
      res.lower = o[63:0];
      res.last = last;
      return res;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      error_count++;
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      block_result_type want;
      if (reset) begin
         key_words = '{default: '0};
         key_code <= '0;
         iv_hi <= '0;
         iv_lo <= '0;
         chain_value <= '0;
         new_message <= 1'b1;
         cipher_results.delete();
         error_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               acbe_pkg::CSR_KEY_WORD_0: key_words[0] = csr_write_data;
               acbe_pkg::CSR_KEY_WORD_1: key_words[1] = csr_write_data;
               acbe_pkg::CSR_KEY_WORD_2: key_words[2] = csr_write_data;
               acbe_pkg::CSR_KEY_WORD_3: key_words[3] = csr_write_data;
               acbe_pkg::CSR_KEY_SIZE:   key_code = csr_write_data[1:0];
               acbe_pkg::CSR_IV_UPPER:   iv_hi = csr_write_data;
               acbe_pkg::CSR_IV_LOWER:   iv_lo = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            cipher_results.push_back(chain_step(req_action, {req_data_upper, req_data_lower},
                                                req_final_block));
         if (rsp_valid && !rsp_stall) begin
            if (cipher_results.size() == 0) begin
               report("unexpected beat", rsp_result_upper, '0);
            end else begin
               want = cipher_results.pop_front();
               if (rsp_result_upper !== want.upper)
                  report("result_upper", rsp_result_upper, want.upper);
               if (rsp_result_lower !== want.lower)
                  report("result_lower", rsp_result_lower, want.lower);
               if (rsp_result_final !== want.last)
                  report("result_final", 64'(rsp_result_final), 64'(want.last));
            end
         end
      end
   end

endmodule

// File: test/tb_aes_cbc_block_engine_top.sv
module tb_aes_cbc_block_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       ACT_ENCRYPT = 1'b0;
   localparam logic       ACT_DECRYPT = 1'b1;
   localparam logic [1:0] KEY_SIZE_256 = 2'd2;
   localparam logic [1:0] KEY_SIZE_ALIAS = 2'd3;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [63:0] ONES = '1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [63:0] req_data_upper;
   logic [63:0] req_data_lower;
   logic        req_final_block;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result_upper;
   logic [63:0] rsp_result_lower;
   logic        rsp_result_final;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [63:0] csr_write_data;
   int          failures;
   int          pending;
   int          cycles;
   int          hold_asked;
   int          hold_done;
   int          blocks_sent;
   int          messages_sent;
   logic        calm;

   aes_cbc_block_engine_top dut (.*);
   acbe_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      hold_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_done) begin
            hold_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 22;
         end
      end
   end

   function automatic logic [63:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic end_writes();
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [1:0] size, input logic [63:0] ivu,
                                input logic [63:0] ivl);
      write_reg(acbe_pkg::CSR_KEY_WORD_0, k0);
      write_reg(acbe_pkg::CSR_KEY_WORD_1, k1);
      write_reg(acbe_pkg::CSR_KEY_WORD_2, k2);
      write_reg(acbe_pkg::CSR_KEY_WORD_3, k3);
      write_reg(acbe_pkg::CSR_KEY_SIZE, {$urandom, 30'h0, size});
      write_reg(acbe_pkg::CSR_IV_UPPER, ivu);
      write_reg(acbe_pkg::CSR_IV_LOWER, ivl);
      write_reg(CSR_UNUSED, {$urandom, $urandom});
      end_writes();
   endtask

   task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo,
                             input logic last);
      if (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_upper <= hi;
      req_data_lower <= lo;
      req_final_block <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      blocks_sent++;
      if (last) messages_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      logic act;
      int   len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_ENCRYPT;
      req_data_upper = '0;
      req_data_lower = '0;
      req_final_block = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      hold_asked = 0;
      blocks_sent = 0;
      messages_sent = 0;
      calm = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings first, then the standard AES-128 example, then the extremes.
      send_block(ACT_ENCRYPT, '0, '0, 1'b0);
      send_block(ACT_DECRYPT, ONES, ONES, 1'b1);
      drain();
      load_settings(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0,
                    acbe_pkg::KEY_SIZE_128, '0, '0);
      send_block(ACT_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      send_block(ACT_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
      drain();
      load_settings(ONES, ONES, ONES, ONES, acbe_pkg::KEY_SIZE_192, ONES, ONES);
      send_block(ACT_ENCRYPT, ONES, ONES, 1'b0);
      send_block(ACT_ENCRYPT, '0, '0, 1'b1);
      send_block(ACT_DECRYPT, ONES, '0, 1'b0);
      send_block(ACT_DECRYPT, '0, ONES, 1'b1);
      drain();
      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, KEY_SIZE_256, {$urandom, $urandom}, '0);
      send_block(ACT_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      send_block(ACT_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      drain();
      // The key and IV change in the middle of a message; only the key applies at once.
      write_reg(acbe_pkg::CSR_KEY_WORD_3, {$urandom, $urandom});
      write_reg(acbe_pkg::CSR_IV_LOWER, ONES);
      end_writes();
      send_block(ACT_DECRYPT, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      send_block(ACT_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
      drain();
      load_settings('0, '0, '0, '0, KEY_SIZE_ALIAS, '0, ONES);
      send_block(ACT_ENCRYPT, '0, '0, 1'b0);
      send_block(ACT_DECRYPT, ONES, ONES, 1'b1);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase % 5 == 0)
            load_settings('0, '0, '0, '0, 2'(phase % 4), '0, '0);
         else if (phase % 5 == 1)
            load_settings(ONES, ONES, ONES, ONES, 2'(phase % 4), ONES, ONES);
         else
            load_settings(pick_word(), pick_word(), pick_word(), pick_word(), 2'(phase % 4),
                          pick_word(), pick_word());
         calm = (phase == 3);
         for (int n = 0; n < 163; n += len) begin
            len = $urandom_range(1, 8);
            act = 1'($urandom);
            if (phase == 5 && n >= 40 && n < 48) hold_asked = 1;
            if (phase == 8 && n >= 80 && n < 88) drain();
            for (int b = 0; b < len; b++) begin
               if ($urandom_range(9) == 0) act = ~act;
               send_block(act, pick_word(), pick_word(),
                          b == len - 1 || $urandom_range(19) == 0);
            end
         end
         drain();
      end

      $display("Ran %0d blocks in %0d messages, encrypt and decrypt, with AES-128/192/256",
               blocks_sent, messages_sent);
      $display("keys, key size alias code, mid-message key and IV writes and a long stall.");
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
